@@ rtl/core/combined_lcg_shuffle_rng_defines.svh @@
// Assertion macros shared by the random number generator RTL.
`ifndef COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_RNG_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CLSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CLSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLSR_ASSERT(lbl, prop, msg)
`define CLSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/clsr_pkg.sv @@
// Constants and types of the combined congruential generator with shuffle table.
package clsr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 8);
    localparam int VAL_W       = 31;
    localparam int MUL_B_W     = 16;
    localparam int PROD_W      = VAL_W + MUL_B_W;
    localparam int RECIP_SHIFT = 40;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;

    localparam logic [VAL_W-1:0]   MOD1         = 31'd2147483563;
    localparam logic [VAL_W-1:0]   MOD2         = 31'd2147483399;
    localparam logic [MUL_B_W-1:0] MULT1        = 16'd40014;
    localparam logic [MUL_B_W-1:0] MULT2        = 16'd40692;
    localparam logic [VAL_W-1:0]   SECOND_RESET = 31'd123456789;
    localparam logic [VAL_W-1:0]   MAXOUT       = MOD1 - 31'd1;

    localparam logic [7:0] FOLD_C1 = 8'(32'h8000_0000 - 32'(MOD1));
    localparam logic [7:0] FOLD_C2 = 8'(32'h8000_0000 - 32'(MOD2));

    localparam logic [VAL_W-1:0]   SLOT_DIV = 31'(1 + MAXOUT / TABLE_DEPTH);
    localparam logic [MUL_B_W-1:0] RECIP    = 16'((64'd1 << RECIP_SHIFT) / 64'(SLOT_DIV));

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_RS_MUL  = 14'b00000000000010,
        ST_RS_FOLD = 14'b00000000000100,
        ST_RS_FIN  = 14'b00000000001000,
        ST_D1_MUL  = 14'b00000000010000,
        ST_D1_FOLD = 14'b00000000100000,
        ST_D1_FIN  = 14'b00000001000000,
        ST_D2_MUL  = 14'b00000010000000,
        ST_D2_FOLD = 14'b00000100000000,
        ST_D2_FIN  = 14'b00001000000000,
        ST_Q_MUL   = 14'b00010000000000,
        ST_Q_MUL2  = 14'b00100000000000,
        ST_Q_FIX   = 14'b01000000000000,
        ST_RES     = 14'b10000000000000
    } state_t;

endpackage

@@ rtl/core/combined_lcg_shuffle_rng.sv @@
// Top level of the combined congruential generator with Bays-Durham shuffle table.
// Draws run in sequence through one shared 31x16 multiplier, which steps both generators and the slot,
// and one modular folder for both generators; a new request is taken only once the draw is back in idle.
// A reseed first runs a warm-up of the first generator through the same unit, which fills the table.
// aresetn (synchronous) restores the generators and prev_out; table valid bits make
// every entry read as zero until it is written.
`include "combined_lcg_shuffle_rng_defines.svh"
module combined_lcg_shuffle_rng (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [30:0] s_seed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_value
);

    localparam int VW = clsr_pkg::VAL_W;
    localparam int PW = clsr_pkg::PROD_W;
    localparam int SW = clsr_pkg::SLOT_W;
    localparam int CW = clsr_pkg::CNT_W;
    localparam int QW = clsr_pkg::Q_W;
    localparam int BW = clsr_pkg::MUL_B_W;

    clsr_pkg::state_t state_reg, state_next;

    logic [VW-1:0]   first_gen_reg, first_gen_next;
    logic [VW-1:0]   second_gen_reg, second_gen_next;
    logic [VW-1:0]   prev_out_reg, prev_out_next;
    logic [VW-1:0]   value_reg, value_next;
    logic            m_valid_reg, m_valid_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]   prod_reg, prod_next;
    logic [31:0]     sum_reg, sum_next;
    logic [QW-1:0]   q0_reg, q0_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [clsr_pkg::TABLE_DEPTH-1:0] tbl_valid_reg, tbl_valid_next;
    logic            valid_rd_reg;

    logic [VW-1:0]   mul_a;
    logic [BW-1:0]   mul_b;
    logic            use_gen2;
    logic [7:0]      fold_c;
    logic [VW-1:0]   fold_mod;
    logic [31:0]     fin_sum;
    logic [VW-1:0]   fin_res;
    logic [31:0]     rem_val;
    logic [QW-1:0]   q_fix;
    logic [SW-1:0]   slot_calc;
    logic            ram_we;
    logic [SW-1:0]   ram_waddr;
    logic [VW-1:0]   ram_wdata;
    logic [SW-1:0]   ram_raddr;
    logic [VW-1:0]   ram_rdata;
    logic [VW-1:0]   tbl_val;
    logic [31:0]     diff;
    logic            out_free;

    clsr_ram #(
        .WIDTH(VW),
        .DEPTH(clsr_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready  = (state_reg == clsr_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_value  = value_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        unique case (state_reg)
            clsr_pkg::ST_D2_MUL: begin
                mul_a = second_gen_reg;
                mul_b = clsr_pkg::MULT2;
            end
            clsr_pkg::ST_Q_MUL: begin
                mul_a = prev_out_reg;
                mul_b = clsr_pkg::RECIP;
            end
            clsr_pkg::ST_Q_MUL2: begin
                mul_a = clsr_pkg::SLOT_DIV;
                mul_b = BW'(prod_reg[PW-1:clsr_pkg::RECIP_SHIFT]);
            end
            default: begin
                mul_a = first_gen_reg;
                mul_b = clsr_pkg::MULT1;
            end
        endcase
    end

    assign use_gen2 = (state_reg == clsr_pkg::ST_D2_FOLD) || (state_reg == clsr_pkg::ST_D2_FIN);
    assign fold_c   = use_gen2 ? clsr_pkg::FOLD_C2 : clsr_pkg::FOLD_C1;
    assign fold_mod = use_gen2 ? clsr_pkg::MOD2 : clsr_pkg::MOD1;
    assign prod_next = PW'(mul_a) * PW'(mul_b);
    assign sum_next  = {1'b0, prod_reg[VW-1:0]} + 32'(prod_reg[PW-1:VW]) * 32'(fold_c);
    assign fin_sum   = {1'b0, sum_reg[VW-1:0]} + (sum_reg[31] ? 32'(fold_c) : 32'd0);
    assign fin_res   = (fin_sum >= {1'b0, fold_mod}) ? VW'(fin_sum - {1'b0, fold_mod})
                                                     : fin_sum[VW-1:0];

    assign rem_val   = {1'b0, prev_out_reg} - prod_reg[31:0];
    assign q_fix     = (rem_val >= {1'b0, clsr_pkg::SLOT_DIV}) ? q0_reg + QW'(1) : q0_reg;
    assign slot_calc = (q_fix >= QW'(clsr_pkg::TABLE_DEPTH)) ? SW'(clsr_pkg::TABLE_DEPTH - 1)
                                                               : q_fix[SW-1:0];
    assign ram_raddr = (state_reg == clsr_pkg::ST_Q_FIX) ? slot_calc : slot_reg;

    assign tbl_val = valid_rd_reg ? ram_rdata : '0;
    assign diff    = {1'b0, tbl_val} - {1'b0, second_gen_reg};

    always_comb begin
        state_next      = state_reg;
        first_gen_next  = first_gen_reg;
        second_gen_next = second_gen_reg;
        prev_out_next   = prev_out_reg;
        value_next      = value_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cnt_next        = cnt_reg;
        q0_next         = q0_reg;
        slot_next       = slot_reg;
        tbl_valid_next  = tbl_valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg;
        ram_wdata       = first_gen_reg;
        unique case (state_reg)
            clsr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd) begin
                        first_gen_next = (s_seed == '0) ? VW'(1) : s_seed;
                        cnt_next       = CW'(clsr_pkg::TABLE_DEPTH + 7);
                        state_next     = clsr_pkg::ST_RS_MUL;
                    end else begin
                        state_next = clsr_pkg::ST_D1_MUL;
                    end
                end
            end
            clsr_pkg::ST_RS_MUL:  state_next = clsr_pkg::ST_RS_FOLD;
            clsr_pkg::ST_RS_FOLD: state_next = clsr_pkg::ST_RS_FIN;
            clsr_pkg::ST_RS_FIN: begin
                first_gen_next = fin_res;
                if (cnt_reg < CW'(clsr_pkg::TABLE_DEPTH)) begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[SW-1:0];
                    ram_wdata = fin_res;
                    tbl_valid_next[cnt_reg[SW-1:0]] = 1'b1;
                end
                if (cnt_reg == '0) begin
                    prev_out_next = fin_res;
                    state_next    = clsr_pkg::ST_D1_MUL;
                end else begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = clsr_pkg::ST_RS_MUL;
                end
            end
            clsr_pkg::ST_D1_MUL:  state_next = clsr_pkg::ST_D1_FOLD;
            clsr_pkg::ST_D1_FOLD: state_next = clsr_pkg::ST_D1_FIN;
            clsr_pkg::ST_D1_FIN: begin
                first_gen_next = fin_res;
                state_next     = clsr_pkg::ST_D2_MUL;
            end
            clsr_pkg::ST_D2_MUL:  state_next = clsr_pkg::ST_D2_FOLD;
            clsr_pkg::ST_D2_FOLD: state_next = clsr_pkg::ST_D2_FIN;
            clsr_pkg::ST_D2_FIN: begin
                second_gen_next = fin_res;
                state_next      = clsr_pkg::ST_Q_MUL;
            end
            clsr_pkg::ST_Q_MUL: state_next = clsr_pkg::ST_Q_MUL2;
            clsr_pkg::ST_Q_MUL2: begin
                q0_next    = prod_reg[PW-1:clsr_pkg::RECIP_SHIFT];
                state_next = clsr_pkg::ST_Q_FIX;
            end
            clsr_pkg::ST_Q_FIX: begin
                slot_next  = slot_calc;
                state_next = clsr_pkg::ST_RES;
            end
            clsr_pkg::ST_RES: begin
                if (out_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_reg;
                    ram_wdata = first_gen_reg;
                    tbl_valid_next[slot_reg] = 1'b1;
                    if (diff[31] || (diff == '0)) begin
                        value_next = VW'(diff + {1'b0, clsr_pkg::MAXOUT});
                    end else begin
                        value_next = diff[VW-1:0];
                    end
                    prev_out_next = value_next;
                    m_valid_next  = 1'b1;
                    state_next    = clsr_pkg::ST_IDLE;
                end
            end
            default: state_next = clsr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= clsr_pkg::ST_IDLE;
            first_gen_reg  <= VW'(1);
            second_gen_reg <= clsr_pkg::SECOND_RESET;
            prev_out_reg   <= '0;
            m_valid_reg    <= 1'b0;
            tbl_valid_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            first_gen_reg  <= first_gen_next;
            second_gen_reg <= second_gen_next;
            prev_out_reg   <= prev_out_next;
            m_valid_reg    <= m_valid_next;
            tbl_valid_reg  <= tbl_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        sum_reg      <= sum_next;
        q0_reg       <= q0_next;
        slot_reg     <= slot_next;
        valid_rd_reg <= tbl_valid_reg[ram_raddr];
    end

    `CLSR_ASSERT(a_slot_in_range, (state_reg == clsr_pkg::ST_Q_FIX) |-> (q_fix < QW'(clsr_pkg::TABLE_DEPTH)), "Slot quotient out of range.")
    `CLSR_ASSERT(a_value_range, m_valid_reg |-> ((value_reg != '0) && (value_reg <= clsr_pkg::MAXOUT)), "Output value out of range.")
    `CLSR_ASSERT_NEXT(a_gen2_reduced, state_reg == clsr_pkg::ST_D2_FIN, second_gen_reg < clsr_pkg::MOD2, "Second generator not reduced.")
    `CLSR_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, state_reg != clsr_pkg::ST_IDLE, "Transaction accepted but sequencer idle.")

endmodule

@@ rtl/core/clsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
